// ===== sv/rcs_pkg.sv =====
// Package for the RGB contrast stretch block: widths, constants, FSM state,
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rcs_pkg;

	localparam int CHANNELS = 3;
	localparam int PIX_W    = 8;
	localparam int QUO_W    = PIX_W;
	localparam int CNT_W    = $clog2(QUO_W);

	localparam logic [PIX_W-1:0] FULL_SCALE = {PIX_W{1'b1}};
	localparam logic [PIX_W-1:0] PIX_ZERO   = '0;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic measure;  // fold the accepted pixel into the statistics
		logic capture;  // latch the accepted stretch pixel's operands
		logic prep;     // form the numerator and seed the dividers
		logic step;     // one restoring division step in every channel
		logic emit;     // load the result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free; // output register is empty or is taken this cycle
	} stat_t;

endpackage
`default_nettype wire

// ===== sv/rgb_contrast_stretch.sv =====
// Per-channel min-max contrast stretch of 8-bit RGB pixels; top level.
// A measure beat gives no result. A stretch beat holds the input through
// capture, numerator, 8 divide steps and result write; the result write
// waits while the output register is still full. Reset (arst_n low) sets
// minima to 255 and maxima to 0. Depends on rcs_pkg, rcs_ctrl and rcs_dp.
`timescale 1ns / 1ps
`default_nettype none
module rgb_contrast_stretch
	import rcs_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        action,
	input  wire        first,
	input  wire  [7:0] red_in,
	input  wire  [7:0] green_in,
	input  wire  [7:0] blue_in,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);

	// The controller owns the handshake and the step count; the datapath
	// owns every data register. They talk only through cmd and stat.
	cmd_t  cmd;
	stat_t stat;
	pix_t  pix [CHANNELS];
	pix_t  res [CHANNELS];

	// Channel order is red, green, blue throughout the datapath.
	assign pix[0] = red_in;
	assign pix[1] = green_in;
	assign pix[2] = blue_in;

	assign red_out   = res[0];
	assign green_out = res[1];
	assign blue_out  = res[2];

	rcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Each stretch value is floor((c - low) * 255 / (high - low)), found by
	// a restoring divider per channel, one quotient bit per cycle. Values at
	// or below the minimum and channels with no spread give 0; values at or
	// above the maximum give 255. The output register frees the input side
	// while a finished beat waits downstream.
	rcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.first     (first),
		.pix       (pix),
		.res       (res),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

endmodule
`default_nettype wire

// ===== sv/rcs_ctrl.sv =====
// Controller of the RGB contrast stretch block: input handshake and the
// sequence capture, prepare, eight divide steps, result write. Uses rcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcs_ctrl
	import rcs_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_stall,
	input  wire   action,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (action) begin
						cmd.capture = 1'b1;
						state_d     = ST_PREP;
					end else begin
						cmd.measure = 1'b1;
					end
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d    = '0;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/rcs_dp.sv =====
// Datapath of the RGB contrast stretch block: per-channel min/max statistics,
// three radix-2 restoring dividers and the output register. Uses rcs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rcs_dp
	import rcs_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  cmd_t  cmd,
	output stat_t stat,
	input  wire   first,
	input  pix_t  pix [CHANNELS],
	output pix_t  res [CHANNELS],
	output logic  out_valid,
	input  wire   out_stall
);

	pix_t low_q  [CHANNELS];
	pix_t high_q [CHANNELS];
	pix_t diff_q [CHANNELS];
	pix_t den_q  [CHANNELS];
	logic zero_q [CHANNELS];
	logic full_q [CHANNELS];
	pix_t rem_q  [CHANNELS];
	pix_t bits_q [CHANNELS];
	pix_t quo_q  [CHANNELS];
	pix_t res_q  [CHANNELS];
	logic out_valid_q;

	assign stat.out_free = !out_valid_q || !out_stall;
	assign out_valid     = out_valid_q;

	for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
		logic [2*PIX_W-1:0] num;
		logic [PIX_W:0]     cand;
		logic               ge;
		logic [PIX_W:0]     sub;

		// (c - low) * 255 as a shift and subtract.
		assign num  = {diff_q[k], PIX_ZERO} - {PIX_ZERO, diff_q[k]};
		assign cand = {rem_q[k], bits_q[k][PIX_W-1]};
		assign ge   = cand >= {1'b0, den_q[k]};
		assign sub  = cand - {1'b0, den_q[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				low_q[k]  <= FULL_SCALE;
				high_q[k] <= PIX_ZERO;
			end else if (cmd.measure) begin
				if (first) begin
					low_q[k]  <= pix[k];
					high_q[k] <= pix[k];
				end else begin
					if (pix[k] < low_q[k]) begin
						low_q[k] <= pix[k];
					end
					if (pix[k] > high_q[k]) begin
						high_q[k] <= pix[k];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.capture) begin
				diff_q[k] <= pix[k] - low_q[k];
				den_q[k]  <= high_q[k] - low_q[k];
				zero_q[k] <= (high_q[k] <= low_q[k]) || (pix[k] <= low_q[k]);
				full_q[k] <= pix[k] >= high_q[k];
			end
			if (cmd.prep) begin
				// The quotient fits in eight bits, so the upper numerator
				// byte is already below the divisor.
				rem_q[k]  <= num[2*PIX_W-1:PIX_W];
				bits_q[k] <= num[PIX_W-1:0];
				quo_q[k]  <= PIX_ZERO;
			end else if (cmd.step) begin
				rem_q[k]  <= ge ? sub[PIX_W-1:0] : cand[PIX_W-1:0];
				bits_q[k] <= {bits_q[k][PIX_W-2:0], 1'b0};
				quo_q[k]  <= {quo_q[k][PIX_W-2:0], ge};
			end
			if (cmd.emit) begin
				res_q[k] <= zero_q[k] ? PIX_ZERO : (full_q[k] ? FULL_SCALE : quo_q[k]);
			end
		end

		assign res[k] = res_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== sim/tb_rgb_contrast_stretch.sv =====
// Self-checking testbench for rgb_contrast_stretch: a queue-fed driver, a monitor with
// a scoreboard, and an independent predictor of the per-channel min-max stretch.
// Depends on rcs_pkg and the rgb_contrast_stretch RTL.
`timescale 1ns / 1ps
module tb_rgb_contrast_stretch;
	import rcs_pkg::*;

	// Stimulus volume and the shape of the flow-control pattern.
	localparam int RANDOM_BEATS = 1200;
	localparam int IDLE_PCT     = 13;
	// Both sides run without any idling while this many input beats go by.
	localparam int QUIET_FROM   = 700;
	localparam int QUIET_TO     = 900;
	// The receiver holds off once, long enough to back the block up to its input.
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 300;
	// Settling time after the last expected result, so that this settles everything.
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	typedef enum logic {
		ACT_MEASURE = 1'b0,
		ACT_STRETCH = 1'b1
	} act_t;

	typedef pix_t [CHANNELS-1:0] rgb_t;  // index 0 red, 1 green, 2 blue

	typedef struct {
		act_t act;
		logic restart;
		rgb_t pix;
	} pixel_beat_t;

	// One expected output pixel, with the cycle at which its stretch beat was taken.
	typedef struct {
		rgb_t        rgb;
		int unsigned taken_at;
	} expected_pixel_t;

	logic clk;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	logic in_stall;
	logic action    = 1'b0;
	logic first     = 1'b0;
	pix_t red_in    = '0;
	pix_t green_in  = '0;
	pix_t blue_in   = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	pix_t red_out;
	pix_t green_out;
	pix_t blue_out;

	pixel_beat_t     pixel_feed[$];
	expected_pixel_t stretched_pixels[$];

	// The predictor's own copy of the running statistics.
	pix_t chan_min[CHANNELS];
	pix_t chan_max[CHANNELS];

	int unsigned cycle_count = 0;
	int          beats_in    = 0;
	int          errors      = 0;
	int          hold_left   = 0;
	logic        hold_fired  = 1'b0;

	rgb_contrast_stretch dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.first     (first),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Map one channel through the stretch. A channel with no spread (max not above
	// min, which includes the state right after reset) gives zero, as does any
	// value at or below the minimum; values at or above the maximum saturate.
	function automatic pix_t stretch_channel(pix_t c, pix_t lo, pix_t hi);
		int unsigned num;
		int unsigned den;
		if (hi <= lo || c <= lo)
			return PIX_ZERO;
		if (c >= hi)
			return FULL_SCALE;
		num = (int'(c) - int'(lo)) * int'(FULL_SCALE);
		den = int'(hi) - int'(lo);
		return pix_t'(num / den);
	endfunction

	// Fold one accepted beat into the statistics, or stretch it against them.
	// Returns 1 when the beat produces an output pixel.
	function automatic bit predict_beat(input act_t act, input logic restart,
			input rgb_t pix, output rgb_t stretched);
		stretched = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			if (act == ACT_STRETCH) begin
				stretched[k] = stretch_channel(pix[k], chan_min[k], chan_max[k]);
			end else if (restart) begin
				chan_min[k] = pix[k];
				chan_max[k] = pix[k];
			end else begin
				// Minimum and maximum are updated independently of each other.
				if (pix[k] < chan_min[k])
					chan_min[k] = pix[k];
				if (pix[k] > chan_max[k])
					chan_max[k] = pix[k];
			end
		end
		return act == ACT_STRETCH;
	endfunction

	function automatic void add_beat(act_t act, logic restart, pix_t r, pix_t g, pix_t b);
		pixel_beat_t pb;
		pb.act     = act;
		pb.restart = restart;
		pb.pix     = {b, g, r};
		pixel_feed.push_back(pb);
	endfunction

	// A value between base and base plus span, saturating at full scale.
	function automatic pix_t band_pix(pix_t base, int span);
		int v;
		v = int'(base) + int'($urandom_range(0, span));
		return (v > 255) ? FULL_SCALE : pix_t'(v);
	endfunction

	// Idle percentage for both sides; zero inside the quiet window.
	function automatic int idle_pct();
		return (beats_in >= QUIET_FROM && beats_in < QUIET_TO) ? 0 : IDLE_PCT;
	endfunction

	function automatic void check_field(string name, pix_t exp_v, pix_t act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Driver. A beat that was on the bus with stall low at this edge was taken, so it
	// goes through the predictor before the next one is offered. Valid only drops or
	// the payload only changes once the current beat has been taken.
	always @(posedge clk) begin
		rgb_t        stretched;
		pixel_beat_t nxt;
		if (!arst_n) begin
			for (int k = 0; k < CHANNELS; k++) begin
				chan_min[k] = FULL_SCALE;
				chan_max[k] = PIX_ZERO;
			end
		end else begin
			if (in_valid && !in_stall) begin
				if (predict_beat(act_t'(action), first, {blue_in, green_in, red_in},
						stretched))
					stretched_pixels.push_back('{rgb: stretched, taken_at: cycle_count});
				beats_in <= beats_in + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pixel_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
					nxt = pixel_feed.pop_front();
					in_valid <= 1'b1;
					action   <= nxt.act;
					first    <= nxt.restart;
					red_in   <= nxt.pix[0];
					green_in <= nxt.pix[1];
					blue_in  <= nxt.pix[2];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. An expectation pushed at this very edge belongs to a beat taken now
	// and cannot be answered yet, so it never matches a result seen at the same edge.
	always @(posedge clk) begin
		expected_pixel_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (stretched_pixels.size() == 0
						|| stretched_pixels[0].taken_at == cycle_count) begin
					$display("%0t: unexpected result, expected none, got %0d %0d %0d",
						$time, red_out, green_out, blue_out);
					errors++;
				end else begin
					e = stretched_pixels.pop_front();
					check_field("red_out", e.rgb[0], red_out);
					check_field("green_out", e.rgb[1], green_out);
					check_field("blue_out", e.rgb[2], blue_out);
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct());
		end
	end

	// The one long receiver hold-off. The sender keeps offering beats meanwhile, so
	// the output register fills and the block has to stall its input.
	always @(posedge clk) begin
		if (!hold_fired && beats_in >= HOLD_AT) begin
			hold_fired <= 1'b1;
			hold_left  <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int   made;
		int   n_meas;
		int   n_str;
		int   span[CHANNELS];
		pix_t base[CHANNELS];
		rgb_t px;

		// Directed part. Stretch straight after reset: bounds are inverted, all zero.
		add_beat(ACT_STRETCH, 1'b0, 8'd0, 8'd128, 8'd255);
		// Red spans 10..200, green 5..100, blue is flat at 77.
		add_beat(ACT_MEASURE, 1'b1, 8'd10, 8'd100, 8'd77);
		add_beat(ACT_MEASURE, 1'b0, 8'd200, 8'd5, 8'd77);
		// Exactly at the minimum, at the maximum, outside on both sides, and inside.
		add_beat(ACT_STRETCH, 1'b0, 8'd10, 8'd5, 8'd77);
		add_beat(ACT_STRETCH, 1'b0, 8'd200, 8'd100, 8'd255);
		add_beat(ACT_STRETCH, 1'b0, 8'd0, 8'd255, 8'd0);
		add_beat(ACT_STRETCH, 1'b0, 8'd105, 8'd52, 8'd77);
		// The restart flag means nothing on a stretch beat.
		add_beat(ACT_STRETCH, 1'b1, 8'd11, 8'd99, 8'd78);
		// A measure inside the range leaves the statistics alone.
		add_beat(ACT_MEASURE, 1'b0, 8'd100, 8'd50, 8'd77);
		add_beat(ACT_STRETCH, 1'b0, 8'd199, 8'd6, 8'd77);
		// Full range on every channel.
		add_beat(ACT_MEASURE, 1'b1, 8'd0, 8'd255, 8'd128);
		add_beat(ACT_MEASURE, 1'b0, 8'd255, 8'd0, 8'd0);
		add_beat(ACT_MEASURE, 1'b0, 8'd128, 8'd128, 8'd255);
		add_beat(ACT_STRETCH, 1'b0, 8'd0, 8'd255, 8'd1);
		add_beat(ACT_STRETCH, 1'b0, 8'd1, 8'd254, 8'd127);
		add_beat(ACT_STRETCH, 1'b0, 8'd170, 8'd85, 8'd255);
		// Red and green span one step, blue is flat: everything lands on 0 or 255.
		add_beat(ACT_MEASURE, 1'b1, 8'd254, 8'd0, 8'd255);
		add_beat(ACT_MEASURE, 1'b0, 8'd255, 8'd1, 8'd255);
		add_beat(ACT_STRETCH, 1'b0, 8'd254, 8'd1, 8'd255);
		add_beat(ACT_STRETCH, 1'b0, 8'd255, 8'd0, 8'd0);

		// Random part: mostly measure runs followed by stretch runs, some with flat or
		// narrow channels, the rest noise with random action and restart flags.
		made = 0;
		while (made < RANDOM_BEATS) begin
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					add_beat(act_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						8'($urandom), 8'($urandom), 8'($urandom));
					made++;
				end
			end else begin
				for (int k = 0; k < CHANNELS; k++) begin
					base[k] = 8'($urandom);
					case ($urandom_range(0, 3))
						0: begin
							span[k] = 0;
						end
						1: begin
							span[k] = $urandom_range(1, 4);
						end
						default: begin
							span[k] = $urandom_range(0, 255);
						end
					endcase
				end
				n_meas = $urandom_range(1, 10);
				n_str  = $urandom_range(1, 10);
				for (int i = 0; i < n_meas; i++) begin
					for (int k = 0; k < CHANNELS; k++)
						px[k] = band_pix(base[k], span[k]);
					// Now and then a run continues the previous statistics.
					add_beat(ACT_MEASURE, i == 0 && $urandom_range(0, 7) != 0,
						px[0], px[1], px[2]);
				end
				for (int i = 0; i < n_str; i++) begin
					for (int k = 0; k < CHANNELS; k++)
						px[k] = $urandom_range(0, 1) ? band_pix(base[k], span[k])
							: 8'($urandom);
					add_beat(ACT_STRETCH, 1'($urandom_range(0, 1)), px[0], px[1], px[2]);
				end
				made += n_meas + n_str;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_feed.size() != 0 || in_valid)
			@(negedge clk);
		while (stretched_pixels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0 && stretched_pixels.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
